// ===== src/mme_pkg.sv =====
// Shared constants, types and helpers for the matrix multiply engine.
// No dependencies; every other file imports this package.
package mme_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OPC_W     = 2;
    localparam int FLD_IDX_W = 3;
    localparam int IN_VAL_W  = 16;
    localparam int PV_W      = 40;

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
    localparam int EXT_W  = (ACC_W > PV_W) ? ACC_W : PV_W;

    localparam logic [CFG_W-1:0]     CFG_RESET_VAL = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic signed [PV_W-1:0] PV_MAX = {1'b0, {(PV_W-1){1'b1}}};
    localparam logic signed [PV_W-1:0] PV_MIN = {1'b1, {(PV_W-1){1'b0}}};

    typedef enum logic [OPC_W-1:0] {
        OP_WRITE_LEFT  = 2'd0,
        OP_WRITE_RIGHT = 2'd1,
        OP_COMPUTE     = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

    // zero counts as one, anything above MAX_DIM clamps to MAX_DIM
    function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_DIM) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return IDX_W'(int'(v) - 1);
        end
    endfunction

    function automatic logic signed [PV_W-1:0] sat_pv(input logic signed [ACC_W-1:0] acc);
        logic signed [EXT_W-1:0] x;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        x  = EXT_W'(acc);
        hi = EXT_W'(PV_MAX);
        lo = EXT_W'(PV_MIN);
        if (x > hi) begin
            return PV_MAX;
        end else if (x < lo) begin
            return PV_MIN;
        end else begin
            return PV_W'(x);
        end
    endfunction

endpackage

// ===== src/matrix_multiply_engine_core.sv =====
// Matrix multiply engine: element stores, sequencer and output register.
// Depends on mme_pkg and mme_mac.
// Load words: one per cycle, no result. Compute word: input stalls while each of rows * cols elements
// is read from the stores, multiplied and accumulated through the single shared multiply-accumulate
// unit, drained and then emitted to the output register, plus any output stalls.
// Reset is synchronous active low; sizes return to 8, stores hold unknown data.
module matrix_multiply_engine_core
    import mme_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OPC_W-1:0]           i_opcode,
    input  logic [FLD_IDX_W-1:0]       i_row_index,
    input  logic [FLD_IDX_W-1:0]       i_col_index,
    input  logic signed [IN_VAL_W-1:0] i_element_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [FLD_IDX_W-1:0]       o_out_row,
    output logic [FLD_IDX_W-1:0]       o_out_col,
    output logic signed [PV_W-1:0]     o_product_value,
    output logic                       o_last
);

    logic [CFG_W-1:0] r_rows_a;
    logic [CFG_W-1:0] r_inner_dim;
    logic [CFG_W-1:0] r_cols_b;

    logic [ELEM_WIDTH-1:0] r_left_mem  [MEM_DEPTH];
    logic [ELEM_WIDTH-1:0] r_right_mem [MEM_DEPTH];
    logic signed [ELEM_WIDTH-1:0] r_left_q;
    logic signed [ELEM_WIDTH-1:0] r_right_q;
    t_mac_ctl r_rd_ctl;

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_nr_last;
    logic [IDX_W-1:0] r_nk_last;
    logic [IDX_W-1:0] r_nc_last;

    logic                   r_out_valid;
    logic [FLD_IDX_W-1:0]   r_out_row;
    logic [FLD_IDX_W-1:0]   r_out_col;
    logic signed [PV_W-1:0] r_out_value;
    logic                   r_out_last;

    logic                   w_in_stall;
    logic                   w_issue;
    logic                   w_emit;
    logic                   w_accept;
    logic                   w_start;
    logic                   w_wr_ok;
    logic                   w_k_last;
    logic                   w_elem_last;
    logic                   w_pipe_empty;
    logic                   w_out_free;
    logic                   w_mac_busy;
    logic signed [PV_W-1:0] w_mac_sum;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [ADDR_W-1:0]      w_rd_addr_l;
    logic [ADDR_W-1:0]      w_rd_addr_r;

    assign w_accept     = i_in_valid && !w_in_stall;
    assign w_start      = w_accept && (t_opcode'(i_opcode) == OP_COMPUTE);
    assign w_wr_ok      = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign w_k_last     = (r_k == r_nk_last);
    assign w_elem_last  = (r_row == r_nr_last) && (r_col == r_nc_last);
    assign w_pipe_empty = !r_rd_ctl.valid && !w_mac_busy;
    assign w_out_free   = !r_out_valid || !i_out_stall;

    assign w_wr_addr   = ADDR_W'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign w_rd_addr_l = ADDR_W'(int'(r_row) * MAX_DIM + int'(r_k));
    assign w_rd_addr_r = ADDR_W'(int'(r_k) * MAX_DIM + int'(r_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_RESET_VAL;
            r_inner_dim <= CFG_RESET_VAL;
            r_cols_b    <= CFG_RESET_VAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_ok) begin
            case (t_opcode'(i_opcode))
                OP_WRITE_LEFT:  r_left_mem[w_wr_addr]  <= ELEM_WIDTH'(i_element_value);
                OP_WRITE_RIGHT: r_right_mem[w_wr_addr] <= ELEM_WIDTH'(i_element_value);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_left_q  <= r_left_mem[w_rd_addr_l];
            r_right_q <= r_right_mem[w_rd_addr_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.valid <= w_issue;
            r_rd_ctl.first <= (r_k == '0);
        end
    end

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_left  (r_left_q),
        .i_right (r_right_q),
        .o_busy  (w_mac_busy),
        .o_sum   (w_mac_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_start)      n_state = ST_ISSUE;
            ST_ISSUE: if (w_k_last)     n_state = ST_DRAIN;
            ST_DRAIN: if (w_pipe_empty) n_state = ST_EMIT;
            ST_EMIT:  if (w_out_free)   n_state = w_elem_last ? ST_IDLE : ST_ISSUE;
            default:                    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_stall = 1'b1;
        w_issue    = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            ST_IDLE:  w_in_stall = 1'b0;
            ST_ISSUE: w_issue    = 1'b1;
            ST_DRAIN: ;
            ST_EMIT:  w_emit     = w_out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
            r_nr_last <= '0;
            r_nk_last <= '0;
            r_nc_last <= '0;
        end else begin
            if (w_start) begin
                r_row     <= '0;
                r_col     <= '0;
                r_k       <= '0;
                r_nr_last <= last_index(r_rows_a);
                r_nk_last <= last_index(r_inner_dim);
                r_nc_last <= last_index(r_cols_b);
            end
            if (w_issue) begin
                r_k <= w_k_last ? '0 : r_k + 1'b1;
            end
            if (w_emit) begin
                if (r_col == r_nc_last) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_row   <= FLD_IDX_W'(r_row);
            r_out_col   <= FLD_IDX_W'(r_col);
            r_out_value <= w_mac_sum;
            r_out_last  <= w_elem_last;
        end
    end

    assign o_in_stall      = w_in_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_pipe_empty)
        else $error("product emitted before accumulation finished");

    a_start_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ST_ISSUE) && (r_k == '0) && (r_row == '0) && (r_col == '0))
        else $error("compute word did not start a clean walk");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_k <= r_nk_last))
        else $error("inner index ran past the inner size");

    a_last_marks_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (o_last == ((o_out_row == FLD_IDX_W'(r_nr_last))
                            && (o_out_col == FLD_IDX_W'(r_nc_last)))))
        else $error("last flag does not match final product element");

endmodule

// ===== src/mme_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulator.
// Depends on mme_pkg for widths, control struct and saturation.
module mme_mac
    import mme_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mac_ctl                     i_ctl,
    input  logic signed [ELEM_WIDTH-1:0] i_left,
    input  logic signed [ELEM_WIDTH-1:0] i_right,
    output logic                         o_busy,
    output logic signed [PV_W-1:0]       o_sum
);

    t_mac_ctl                  r_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_left * i_right;
        end
        if (r_ctl.valid) begin
            if (r_ctl.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_busy = r_ctl.valid;
    assign o_sum  = sat_pv(r_acc);

endmodule

// ===== test/tb_matrix_multiply_engine_core.sv =====
// Self-checking testbench for matrix_multiply_engine_core: loads both element stores,
// runs compute words over many size settings and checks every product word in order.
// Depends on mme_pkg and the RTL of the engine; needs no other file.
module tb_matrix_multiply_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_SETTLE = 20;
    localparam int LIMIT_CYCLES = 600_000;

    typedef struct {
        logic [FLD_IDX_W-1:0] row;
        logic [FLD_IDX_W-1:0] col;
        logic signed [PV_W-1:0] value;
        logic last;
    } t_product_elem;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [OPC_W-1:0] i_opcode = '0;
    logic [FLD_IDX_W-1:0] i_row_index = '0;
    logic [FLD_IDX_W-1:0] i_col_index = '0;
    logic signed [IN_VAL_W-1:0] i_element_value = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b1;
    logic [FLD_IDX_W-1:0] o_out_row;
    logic [FLD_IDX_W-1:0] o_out_col;
    logic signed [PV_W-1:0] o_product_value;
    logic o_last;

    // model state: element stores and size registers
    logic signed [ELEM_WIDTH-1:0] left_mem [MEM_DEPTH];
    logic signed [ELEM_WIDTH-1:0] right_mem [MEM_DEPTH];
    logic [CFG_W-1:0] rows_cfg = CFG_RESET_VAL;
    logic [CFG_W-1:0] inner_cfg = CFG_RESET_VAL;
    logic [CFG_W-1:0] cols_cfg = CFG_RESET_VAL;

    t_product_elem product_q[$];
    t_product_elem want;
    int err_count = 0;
    int hold_len = 0;
    bit in_steady = 1'b0;

    matrix_multiply_engine_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("matrix_multiply_engine_core verification failed");
        $finish;
    end

    function automatic int dim_of(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end else begin
            return int'(v);
        end
    endfunction

    // apply one accepted word to the model and queue the product words it causes
    task automatic predict_word(input logic [OPC_W-1:0] op, input logic [FLD_IDX_W-1:0] row,
                                input logic [FLD_IDX_W-1:0] col,
                                input logic signed [IN_VAL_W-1:0] val);
        int nr;
        int nk;
        int nc;
        longint acc;
        t_product_elem e;
        case (op)
            OP_WRITE_LEFT: begin
                left_mem[int'(row) * MAX_DIM + int'(col)] = val;
            end
            OP_WRITE_RIGHT: begin
                right_mem[int'(row) * MAX_DIM + int'(col)] = val;
            end
            OP_COMPUTE: begin
                nr = dim_of(rows_cfg);
                nk = dim_of(inner_cfg);
                nc = dim_of(cols_cfg);
                for (int i = 0; i < nr; i++) begin
                    for (int j = 0; j < nc; j++) begin
                        acc = 0;
                        for (int k = 0; k < nk; k++) begin
                            acc += longint'(left_mem[i * MAX_DIM + k])
                                 * longint'(right_mem[k * MAX_DIM + j]);
                        end
                        e.row = FLD_IDX_W'(i);
                        e.col = FLD_IDX_W'(j);
                        if (acc > longint'(PV_MAX)) begin
                            e.value = PV_MAX;
                        end else if (acc < longint'(PV_MIN)) begin
                            e.value = PV_MIN;
                        end else begin
                            e.value = PV_W'(acc);
                        end
                        e.last = (i == nr - 1) && (j == nc - 1);
                        product_q.push_back(e);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_word(input logic [OPC_W-1:0] op, input logic [FLD_IDX_W-1:0] row,
                             input logic [FLD_IDX_W-1:0] col,
                             input logic signed [IN_VAL_W-1:0] val);
        int gap;
        if (in_steady) begin
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            gap = $urandom_range(10, 40);
        end else begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_row_index <= row;
        i_col_index <= col;
        i_element_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(op, row, col, val);
    endtask

    task automatic send_random_load(input logic [OPC_W-1:0] op);
        send_word(op, FLD_IDX_W'($urandom_range(0, 7)), FLD_IDX_W'($urandom_range(0, 7)),
                  IN_VAL_W'($urandom));
    endtask

    // drop valid, wait for every product word, then let the engine go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // hold write enable high; the caller drops it after its last write
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ROWS_A: rows_cfg = val;
            CFG_INNER_DIM: inner_cfg = val;
            CFG_COLS_B: cols_cfg = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                             input logic [CFG_W-1:0] c);
        settle();
        write_cfg(CFG_ROWS_A, r);
        write_cfg(CFG_INNER_DIM, k);
        write_cfg(CFG_COLS_B, c);
        i_cfg_we <= 1'b0;
    endtask

    // every entry gets written; row 0 / col 0 full negative, row 1 / col 1 full positive
    task automatic test_fill_stores();
        logic signed [IN_VAL_W-1:0] v;
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                v = (r == 0) ? 16'sh8000 : (r == 1) ? 16'sh7fff : IN_VAL_W'($urandom);
                send_word(OP_WRITE_LEFT, FLD_IDX_W'(r), FLD_IDX_W'(c), v);
            end
        end
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                v = (c == 0) ? 16'sh8000 : (c == 1) ? 16'sh7fff : IN_VAL_W'($urandom);
                send_word(OP_WRITE_RIGHT, FLD_IDX_W'(r), FLD_IDX_W'(c), v);
            end
        end
    endtask

    task automatic test_reset_sizes();
        send_word(OP_COMPUTE, '0, '0, '0);
    endtask

    task automatic test_size_codes();
        set_sizes(4'd0, 4'd0, 4'd0);
        send_word(OP_UNUSED, 3'd7, 3'd7, 16'sh7fff);
        send_word(OP_COMPUTE, 3'd7, 3'd7, 16'sh8000);
        set_sizes(4'd15, 4'd9, 4'd12);
        send_word(OP_COMPUTE, '0, '0, '0);
        settle();
        write_cfg(CFG_ROWS_A, 4'd1);
        write_cfg(CFG_INNER_DIM, 4'd8);
        write_cfg(CFG_COLS_B, 4'd3);
        write_cfg(CFG_SPARE, 4'd5);
        i_cfg_we <= 1'b0;
        send_word(OP_UNUSED, '0, '0, '0);
        send_word(OP_COMPUTE, '0, '0, '0);
        set_sizes(4'd8, 4'd1, 4'd1);
        send_word(OP_COMPUTE, '0, '0, '0);
    endtask

    task automatic test_corner_writes();
        set_sizes(4'd8, 4'd8, 4'd8);
        send_word(OP_WRITE_LEFT, 3'd7, 3'd7, 16'sh7fff);
        send_word(OP_WRITE_RIGHT, 3'd7, 3'd7, 16'sh8000);
        send_word(OP_WRITE_LEFT, 3'd0, 3'd7, -16'sd1);
        send_word(OP_WRITE_RIGHT, 3'd7, 3'd0, 16'sd0);
        send_word(OP_COMPUTE, '0, '0, '0);
    endtask

    // receiver holds off while loads keep coming behind a full-size compute
    task automatic test_backpressure();
        settle();
        hold_len = 400;
        send_word(OP_COMPUTE, '0, '0, '0);
        for (int n = 0; n < 40; n++) begin
            send_random_load(($urandom_range(0, 1) == 0) ? OP_WRITE_LEFT : OP_WRITE_RIGHT);
        end
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        int pick;
        logic [CFG_W-1:0] dims [3];
        sent = 0;
        while (sent < 120) begin
            for (int d = 0; d < 3; d++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    dims[d] = CFG_W'($urandom_range(9, 15));
                end else if (pick == 1) begin
                    dims[d] = '0;
                end else if (pick == 2) begin
                    dims[d] = 4'd8;
                end else begin
                    dims[d] = CFG_W'($urandom_range(1, 4));
                end
            end
            set_sizes(dims[0], dims[1], dims[2]);
            in_steady = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(6, 20);
            for (int n = 0; n < burst; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_random_load(OP_UNUSED);
                end else begin
                    send_random_load((pick < 10) ? OP_WRITE_LEFT : OP_WRITE_RIGHT);
                    sent++;
                end
            end
            send_word(OP_COMPUTE, FLD_IDX_W'($urandom), FLD_IDX_W'($urandom),
                      IN_VAL_W'($urandom));
            sent++;
            if ($urandom_range(0, 3) == 0) begin
                send_word(OP_COMPUTE, '0, '0, '0);
                sent++;
            end
            in_steady = 1'b0;
        end
    endtask

    // receiver stall pattern: short stalls, a few long ones, stretches with none
    initial begin : out_stall_gen
        int stall_left;
        int go_left;
        stall_left = 0;
        go_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                stall_left = hold_len;
                hold_len = 0;
            end
            if (stall_left == 0 && go_left == 0) begin
                go_left = $urandom_range(1, 20);
                if ($urandom_range(0, 7) == 0) begin
                    go_left += 60;
                end
                if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(20, 60);
                end else begin
                    stall_left = $urandom_range(0, 3);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                go_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (product_q.size() == 0) begin
                $display("%0t: unexpected word row %0d col %0d value %0d last %0b", $time,
                         o_out_row, o_out_col, o_product_value, o_last);
                err_count++;
            end else begin
                want = product_q.pop_front();
                if (o_out_row !== want.row) begin
                    $display("%0t: out_row expected %0d actual %0d", $time, want.row,
                             o_out_row);
                    err_count++;
                end
                if (o_out_col !== want.col) begin
                    $display("%0t: out_col expected %0d actual %0d", $time, want.col,
                             o_out_col);
                    err_count++;
                end
                if (o_product_value !== want.value) begin
                    $display("%0t: product_value expected %0d actual %0d", $time,
                             want.value, o_product_value);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    initial begin : run_tests
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_stores();
        test_reset_sizes();
        test_size_codes();
        test_corner_writes();
        test_backpressure();
        test_random_traffic();
        settle();
        if (err_count == 0) begin
            $display("matrix_multiply_engine_core verification clean");
        end else begin
            $display("matrix_multiply_engine_core verification failed");
        end
        $finish;
    end

endmodule
